// ===== design/slrp_pkg.sv =====
`timescale 1ns / 1ps

package slrp_pkg;

    // Default sizing, handed to the top level parameters
    localparam int MAX_WIDTH_DEFAULT       = 4096;
    localparam int MAX_ROWS_DEFAULT        = 4096;
    localparam int LINES_PER_STAFF_DEFAULT = 5;

    // Fixed field widths
    localparam int PIXEL_W  = 8;
    localparam int RUN_W    = 13;
    localparam int ROW_W    = 12;
    localparam int LINES_W  = 3;
    localparam int RATIO_W  = 9;
    localparam int WIDTH_W  = 13;
    localparam int CFG_W    = 13;
    localparam int THRESH_W = RATIO_W + WIDTH_W;

    // Config register reset values
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;
    localparam logic [RATIO_W-1:0] RATIO_Q8_RESET    = 9'd128;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_RATIO_Q8    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               end_of_row;
        logic               end_of_image;
    } pixel_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_number;
        logic [RUN_W-1:0] row_longest_run;
        logic             line_begins;
        logic             staff_ready;
        logic [RUN_W-1:0] staff_center_doubled;
        logic             count_error;
        logic             image_done;
    } row_result_t;

endpackage

// ===== design/slrp_in_stage.sv =====
`timescale 1ns / 1ps

module slrp_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  slrp_pkg::pixel_item_t s_item,
    output logic                 item_valid,
    output slrp_pkg::pixel_item_t item,
    input  logic                 item_take
);

    logic                  valid_reg;
    logic                  valid_next;
    slrp_pkg::pixel_item_t item_reg;

    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/slrp_row_core.sv =====
`timescale 1ns / 1ps

module slrp_row_core #(
    parameter int MAX_WIDTH       = slrp_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_ROWS        = slrp_pkg::MAX_ROWS_DEFAULT,
    parameter int LINES_PER_STAFF = slrp_pkg::LINES_PER_STAFF_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [0:0]                    cfg_index,
    input  logic [slrp_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          item_valid,
    input  slrp_pkg::pixel_item_t         item,
    output logic                          item_take,
    input  logic                          res_ready,
    output logic                          res_valid,
    output slrp_pkg::row_result_t         result
);

    localparam int RunCapInt = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
    localparam int RowCapInt = (MAX_ROWS - 1 < 4095) ? MAX_ROWS - 1 : 4095;
    localparam logic [slrp_pkg::RUN_W-1:0] RUN_CAP = slrp_pkg::RUN_W'(RunCapInt);
    localparam logic [slrp_pkg::ROW_W-1:0] ROW_CAP = slrp_pkg::ROW_W'(RowCapInt);
    localparam logic [slrp_pkg::LINES_W:0] GROUP_SIZE =
        (slrp_pkg::LINES_W + 1)'(LINES_PER_STAFF);

    logic [slrp_pkg::WIDTH_W-1:0] width_reg;
    logic [slrp_pkg::RATIO_W-1:0] ratio_reg;

    logic [slrp_pkg::RUN_W-1:0]   cur_run_reg;
    logic [slrp_pkg::RUN_W-1:0]   longest_reg;
    logic [slrp_pkg::ROW_W-1:0]   row_reg;
    logic                         prev_qual_reg;
    logic [slrp_pkg::LINES_W-1:0] lines_reg;
    logic [slrp_pkg::ROW_W-1:0]   third_reg;
    logic [slrp_pkg::ROW_W-1:0]   fourth_reg;

    logic                          pix_set;
    logic                          row_end;
    logic [slrp_pkg::RUN_W-1:0]    run_next;
    logic [slrp_pkg::RUN_W-1:0]    longest_next;
    logic [slrp_pkg::THRESH_W-1:0] thresh;
    logic [slrp_pkg::THRESH_W-1:0] run_scaled;
    logic                          qualifies;
    logic                          begins;
    logic [slrp_pkg::LINES_W-1:0]  lines_inc;
    logic [slrp_pkg::LINES_W-1:0]  lines_next;
    logic [slrp_pkg::ROW_W-1:0]    third_next;
    logic [slrp_pkg::ROW_W-1:0]    fourth_next;
    logic                          group_done;
    logic [slrp_pkg::RUN_W-1:0]    center;

    always_comb begin
        pix_set = item.pixel != '0;
        row_end = item.end_of_row || item.end_of_image;

        if (!pix_set) begin
            run_next = '0;
        end else if (cur_run_reg < RUN_CAP) begin
            run_next = cur_run_reg + 1'b1;
        end else begin
            run_next = cur_run_reg;
        end
        longest_next = (run_next > longest_reg) ? run_next : longest_reg;

        // run * 256 > ratio * width
        thresh     = slrp_pkg::THRESH_W'(ratio_reg) * slrp_pkg::THRESH_W'(width_reg);
        run_scaled = {1'b0, longest_next, 8'd0};
        qualifies  = run_scaled > thresh;
        begins     = qualifies && !prev_qual_reg;

        lines_inc   = lines_reg + 1'b1;
        third_next  = (begins && lines_inc == 3'd3) ? row_reg : third_reg;
        fourth_next = (begins && lines_inc == 3'd4) ? row_reg : fourth_reg;
        // wrap to zero also closes a group (at the eighth line, when LINES_PER_STAFF is 8 or more)
        group_done  = begins && ({1'b0, lines_inc} >= GROUP_SIZE || lines_inc == '0);
        if (group_done) begin
            lines_next = '0;
        end else if (begins) begin
            lines_next = lines_inc;
        end else begin
            lines_next = lines_reg;
        end
        center = {1'b0, third_next} + {1'b0, fourth_next};

        result.row_number           = row_reg;
        result.row_longest_run      = longest_next;
        result.line_begins          = begins;
        result.staff_ready          = group_done;
        result.staff_center_doubled = group_done ? center : '0;
        result.count_error          = item.end_of_image && (lines_next != '0);
        result.image_done           = item.end_of_image;

        item_take = item_valid && (!row_end || res_ready);
        res_valid = item_valid && row_end && res_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= slrp_pkg::IMAGE_WIDTH_RESET;
            ratio_reg     <= slrp_pkg::RATIO_Q8_RESET;
            cur_run_reg   <= '0;
            longest_reg   <= '0;
            row_reg       <= '0;
            prev_qual_reg <= 1'b0;
            lines_reg     <= '0;
            third_reg     <= '0;
            fourth_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (slrp_pkg::cfg_index_t'(cfg_index))
                    slrp_pkg::CFG_IMAGE_WIDTH: begin
                        width_reg <= cfg_wdata[slrp_pkg::WIDTH_W-1:0];
                    end
                    slrp_pkg::CFG_RATIO_Q8: begin
                        ratio_reg <= cfg_wdata[slrp_pkg::RATIO_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (item_take) begin
                if (row_end) begin
                    cur_run_reg <= '0;
                    longest_reg <= '0;
                    if (item.end_of_image) begin
                        row_reg       <= '0;
                        prev_qual_reg <= 1'b0;
                        lines_reg     <= '0;
                        third_reg     <= '0;
                        fourth_reg    <= '0;
                    end else begin
                        prev_qual_reg <= qualifies;
                        lines_reg     <= lines_next;
                        third_reg     <= group_done ? '0 : third_next;
                        fourth_reg    <= group_done ? '0 : fourth_next;
                        if (row_reg < ROW_CAP) begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                end else begin
                    cur_run_reg <= run_next;
                    longest_reg <= longest_next;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_res_only_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> item_take && row_end)
        else $error("result issued without consuming a row end");

    a_staff_needs_line: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && result.staff_ready |-> result.line_begins)
        else $error("staff closed on a row that starts no line");

    a_image_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && item.end_of_image |=> row_reg == '0 && lines_reg == '0
            && !prev_qual_reg)
        else $error("image state not cleared after last row");

    a_group_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (LINES_PER_STAFF == 8) || ({1'b0, lines_reg} < GROUP_SIZE))
        else $error("line group count out of range");

    a_run_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_run_reg <= RUN_CAP && cur_run_reg <= longest_reg)
        else $error("run counter beyond cap or above row maximum");
`endif

endmodule

// ===== design/slrp_out_stage.sv =====
`timescale 1ns / 1ps

module slrp_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  res_valid,
    input  slrp_pkg::row_result_t result,
    output logic                  res_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output slrp_pkg::row_result_t m_result
);

    logic                  valid_reg;
    logic                  valid_next;
    slrp_pkg::row_result_t result_reg;

    // free when empty or the held item leaves this cycle
    assign res_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== design/staff_line_row_projection.sv =====
`timescale 1ns / 1ps
// A row-end item moves from the input register to the result register once
// the result register is free. Throughput: one pixel item per cycle while no
// row end waits for the result register; one result item per completed row.
// The per-pixel run tracking and the qualify multiply sit between the input
// register and the result register, so each unstalled cycle retires one item.
// Reset (aresetn low, synchronous): both stages empty, row state cleared,
// image_width back to 4096 and ratio_q8 back to 128.

module staff_line_row_projection #(
    parameter int MAX_WIDTH       = slrp_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_ROWS        = slrp_pkg::MAX_ROWS_DEFAULT,
    parameter int LINES_PER_STAFF = slrp_pkg::LINES_PER_STAFF_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration writes: index 0 image_width, index 1 ratio_q8
    input  logic                       cfg_wr_en,
    input  logic [0:0]                 cfg_index,
    input  logic [slrp_pkg::CFG_W-1:0] cfg_wdata,
    // pixel items in raster order
    input  logic                       s_valid,
    output logic                       s_ready,
    input  slrp_pkg::pixel_item_t      s_item,
    // one result item per completed row
    output logic                       m_valid,
    input  logic                       m_ready,
    output slrp_pkg::row_result_t      m_result
);

    logic                  item_valid;
    logic                  item_take;
    slrp_pkg::pixel_item_t item;
    logic                  res_valid;
    logic                  res_ready;
    slrp_pkg::row_result_t result;

    // Input register: takes a new pixel whenever the held one retires.
    slrp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Row tracking, line and staff grouping. Pixels that do not end a row
    // retire without waiting on the output; a row end waits for a free
    // result register.
    slrp_row_core #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_ROWS        (MAX_ROWS),
        .LINES_PER_STAFF (LINES_PER_STAFF)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .result     (result)
    );

    // Result register: holds a finished row while the next pixels flow in.
    slrp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .result    (result),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

// ===== verif/staff_line_row_projection_tb.sv =====
`timescale 1ns / 1ps

module staff_line_row_projection_tb;

    // ---------------------------------------------------------------------
    // Run sizing
    // ---------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 400000;  // well above the slowest legal run
    localparam int DRAIN_CYCLES = 8;       // extra wait after the last expected row
    localparam int STALL_AT     = 40;      // result count that triggers the long hold-off
    localparam int LONG_STALL   = 200;     // cycles m_ready stays low during it
    localparam int PHASE_ITEMS  = 52;
    localparam int N_PHASES     = 7;
    localparam int DIR_N        = 25;
    localparam int DIR_CFG_AT   = 2;       // table row where the narrow-image setup starts

    // Saturation limits of the block at its default sizing
    localparam int RUN_CAP = (slrp_pkg::MAX_WIDTH_DEFAULT < 8191) ?
                             slrp_pkg::MAX_WIDTH_DEFAULT : 8191;
    localparam int ROW_CAP = (slrp_pkg::MAX_ROWS_DEFAULT - 1 < 4095) ?
                             slrp_pkg::MAX_ROWS_DEFAULT - 1 : 4095;

    // ---------------------------------------------------------------------
    // Clock, reset, DUT ports
    // ---------------------------------------------------------------------
    logic                         aclk      = 1'b0;
    logic                         aresetn   = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [0:0]                   cfg_index = slrp_pkg::CFG_IMAGE_WIDTH;
    logic [slrp_pkg::CFG_W-1:0]   cfg_wdata = '0;
    logic                         s_valid   = 1'b0;
    logic                         s_ready;
    slrp_pkg::pixel_item_t        s_item    = '0;
    logic                         m_valid;
    logic                         m_ready   = 1'b0;
    slrp_pkg::row_result_t        m_result;

    always #2 aclk = ~aclk;

    staff_line_row_projection u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    // ---------------------------------------------------------------------
    // Scoreboard state
    // ---------------------------------------------------------------------
    slrp_pkg::row_result_t row_results [$];   // predicted per-row results, oldest first
    int          mismatches   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    bit          idle_on      = 1'b1; // both sides insert random gaps when set

    // ---------------------------------------------------------------------
    // Row projection predictor: its own copy of config and per-image state
    // ---------------------------------------------------------------------
    logic [slrp_pkg::WIDTH_W-1:0] cfg_w;
    logic [slrp_pkg::RATIO_W-1:0] cfg_r;
    logic [slrp_pkg::RUN_W-1:0]   run_now;
    logic [slrp_pkg::RUN_W-1:0]   run_best;
    logic [slrp_pkg::ROW_W-1:0]   row_ctr;
    logic                         prev_qual;
    logic [slrp_pkg::LINES_W-1:0] line_cnt;
    logic [slrp_pkg::ROW_W-1:0]   third_row;
    logic [slrp_pkg::ROW_W-1:0]   fourth_row;

    function automatic void clear_image_state();
        run_now    = '0;
        run_best   = '0;
        row_ctr    = '0;
        prev_qual  = 1'b0;
        line_cnt   = '0;
        third_row  = '0;
        fourth_row = '0;
    endfunction

    // Advances the row state by one pixel; returns 1 when the pixel closes a row.
    function automatic bit predict_row(input slrp_pkg::pixel_item_t it,
                                       output slrp_pkg::row_result_t res);
        logic [slrp_pkg::THRESH_W-1:0] run_scaled;
        logic [slrp_pkg::THRESH_W-1:0] limit;
        logic                          qual;
        logic                          begins;
        res = '0;
        if (it.pixel != '0) begin
            if (int'(run_now) < RUN_CAP)
                run_now = run_now + 1'b1;
        end else begin
            run_now = '0;
        end
        if (run_now > run_best)
            run_best = run_now;
        if (!it.end_of_row && !it.end_of_image)
            return 1'b0;

        // run/width > ratio/256 (ratio in Q8), kept exact in fixed point
        run_scaled = slrp_pkg::THRESH_W'(run_best) << 8;
        limit      = slrp_pkg::THRESH_W'(cfg_r) * slrp_pkg::THRESH_W'(cfg_w);
        qual       = run_scaled > limit;
        begins     = qual && !prev_qual;
        prev_qual  = qual;

        res.row_number      = row_ctr;
        res.row_longest_run = run_best;
        res.line_begins     = begins;
        if (begins) begin
            line_cnt = line_cnt + 1'b1;
            if (line_cnt == 3)
                third_row = row_ctr;
            if (line_cnt == 4)
                fourth_row = row_ctr;
            if (int'(line_cnt) >= slrp_pkg::LINES_PER_STAFF_DEFAULT || line_cnt == 0) begin
                res.staff_ready          = 1'b1;
                res.staff_center_doubled = {1'b0, third_row} + {1'b0, fourth_row};
                line_cnt   = '0;
                third_row  = '0;
                fourth_row = '0;
            end
        end
        if (it.end_of_image)
            res.count_error = (line_cnt != 0);
        res.image_done = it.end_of_image;

        run_now  = '0;
        run_best = '0;
        if (it.end_of_image)
            clear_image_state();
        else if (int'(row_ctr) < ROW_CAP)
            row_ctr = row_ctr + 1'b1;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------
    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_row(input slrp_pkg::row_result_t got);
        slrp_pkg::row_result_t want;
        if (row_results.size() == 0) begin
            report($sformatf("result for row %0d with nothing expected", got.row_number));
            return;
        end
        want = row_results.pop_front();
        if (got.row_number != want.row_number)
            report($sformatf("row_number %0d, want %0d", got.row_number, want.row_number));
        if (got.row_longest_run != want.row_longest_run)
            report($sformatf("row %0d row_longest_run %0d, want %0d", want.row_number,
                             got.row_longest_run, want.row_longest_run));
        if (got.line_begins != want.line_begins)
            report($sformatf("row %0d line_begins %0b, want %0b", want.row_number,
                             got.line_begins, want.line_begins));
        if (got.staff_ready != want.staff_ready)
            report($sformatf("row %0d staff_ready %0b, want %0b", want.row_number,
                             got.staff_ready, want.staff_ready));
        if (got.staff_center_doubled != want.staff_center_doubled)
            report($sformatf("row %0d staff_center_doubled %0d, want %0d", want.row_number,
                             got.staff_center_doubled, want.staff_center_doubled));
        if (got.count_error != want.count_error)
            report($sformatf("row %0d count_error %0b, want %0b", want.row_number,
                             got.count_error, want.count_error));
        if (got.image_done != want.image_done)
            report($sformatf("row %0d image_done %0b, want %0b", want.row_number,
                             got.image_done, want.image_done));
    endtask

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------
    // Offers one pixel item and returns in the step it is accepted. Valid is
    // left high so a back-to-back item never sees valid drop and rise in one
    // step; the next call lowers it only before a gap, and drain_rows lowers it.
    task automatic push_pixel(input slrp_pkg::pixel_item_t it, input bit typed,
                              input slrp_pkg::row_result_t want);
        int                    gap;
        slrp_pkg::row_result_t res;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (predict_row(it, res))
            row_results.insert(row_results.size(), typed ? want : res);
    endtask

    // Quiet the input and let every expected row come out, plus the pipeline
    // depth for pixels that make no result.
    task automatic drain_rows();
        s_valid <= 1'b0;
        do @(posedge aclk); while (row_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only called when drained; both registers go in back to back.
    task automatic set_config(input logic [slrp_pkg::WIDTH_W-1:0] width,
                              input logic [slrp_pkg::RATIO_W-1:0] ratio);
        cfg_wr_en <= 1'b1;
        cfg_index <= slrp_pkg::CFG_IMAGE_WIDTH;
        cfg_wdata <= slrp_pkg::CFG_W'(width);
        @(posedge aclk);
        cfg_index <= slrp_pkg::CFG_RATIO_Q8;
        cfg_wdata <= slrp_pkg::CFG_W'(ratio);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_w = width;
        cfg_r = ratio;
    endtask

    // Random images: mostly rows of the configured width with dense or sparse
    // content so lines and staffs form; some rows are off-width, some images
    // end without a row end, and a few are cut short mid-row. The last item
    // of a phase always ends its image.
    task automatic run_images(input logic [slrp_pkg::WIDTH_W-1:0] width,
                              input logic [slrp_pkg::RATIO_W-1:0] ratio,
                              input bit idling, input int budget);
        int                    sent;
        int                    nrows;
        int                    len;
        bit                    dense;
        bit                    done_img;
        slrp_pkg::pixel_item_t it;
        drain_rows();
        set_config(width, ratio);
        idle_on = idling;
        sent    = 0;
        while (sent < budget) begin
            nrows    = $urandom_range(1, 12);
            done_img = 1'b0;
            for (int r = 0; r < nrows && !done_img; r++) begin
                if (width == 0 || $urandom_range(0, 6) == 0)
                    len = $urandom_range(1, 2 * int'(width) + 3);
                else
                    len = width;
                dense = 1'($urandom_range(0, 1));
                for (int c = 0; c < len && !done_img; c++) begin
                    if ($urandom_range(0, 9) < (dense ? 9 : 2))
                        it.pixel = 8'($urandom_range(1, 255));
                    else
                        it.pixel = '0;
                    it.end_of_row   = (c == len - 1);
                    it.end_of_image = 1'b0;
                    if ((r == nrows - 1 && c == len - 1) || sent == budget - 1) begin
                        it.end_of_image = 1'b1;
                        it.end_of_row   = ($urandom_range(0, 4) != 0);
                        done_img        = 1'b1;
                    end else if ($urandom_range(0, 199) == 0) begin
                        // broken image: ends mid-row
                        it.end_of_image = 1'b1;
                        it.end_of_row   = 1'($urandom_range(0, 1));
                        done_img        = 1'b1;
                    end
                    push_pixel(it, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: random hold-offs per item, one long hold-off once so
    // the block backs up and stalls its input.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_row(m_result);
                results_seen++;
                hold = idle_on ? $urandom_range(0, 5) : 0;
                if (results_seen == STALL_AT)
                    hold = LONG_STALL;
            end else if (hold > 0) begin
                hold--;
            end
            m_ready <= (hold == 0);
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    typedef struct packed {
        slrp_pkg::pixel_item_t item;
        logic                  typed;   // want holds a hand-written result
        slrp_pkg::row_result_t want;
    } dir_row_t;

    dir_row_t dir_tab [DIR_N];

    int          phase_width [N_PHASES] = '{8, 1, 0, 12, 5, 3, 16};
    int          phase_ratio [N_PHASES] = '{128, 256, 0, 511, 64, 200, 255};

    initial begin : stimulus
        // Rows 0-1 run with the reset registers (width 4096, ratio 128): one
        // pixel images, no line possible. The rest uses width 2, ratio 128,
        // so a row with both pixels set qualifies. Lines start at rows
        // 0, 2, 4, 7, 9 (row 5 qualifies but continues the row-4 line), the
        // fifth closes a staff with center 4 + 7. After a blank row one more
        // line starts at row 11, where the image ends without a row end,
        // leaving the count uneven.
        dir_tab = '{
            '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{12'd0, 13'd0, 1'b0, 1'b0, 13'd0, 1'b0, 1'b1}},
            '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{12'd0, 13'd1, 1'b0, 1'b0, 13'd0, 1'b0, 1'b1}},
            '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h80, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h01, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h10, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h20, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h40, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'hAA, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h55, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h02, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'h04, 1'b1, 1'b0}, 1'b1, '{12'd9, 13'd2, 1'b1, 1'b1, 13'd11, 1'b0, 1'b0}},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
            '{'{8'h08, 1'b0, 1'b0}, 1'b0, '0},
            '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{12'd11, 13'd2, 1'b1, 1'b0, 13'd0, 1'b1, 1'b1}}
        };

        cfg_w = slrp_pkg::IMAGE_WIDTH_RESET;
        cfg_r = slrp_pkg::RATIO_Q8_RESET;
        clear_image_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (i == DIR_CFG_AT) begin
                drain_rows();
                set_config(13'd2, 9'd128);
            end
            push_pixel(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end

        // Random images across register settings, zero width and the
        // ratio extremes among them; every third phase runs without gaps.
        for (int p = 0; p < N_PHASES; p++)
            run_images(slrp_pkg::WIDTH_W'(phase_width[p]), slrp_pkg::RATIO_W'(phase_ratio[p]),
                       (p % 3) != 2, PHASE_ITEMS);

        // A short image after the cleared state, back at the reset setting.
        run_images(slrp_pkg::IMAGE_WIDTH_RESET, slrp_pkg::RATIO_Q8_RESET, 1'b1, 8);

        drain_rows();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== staff_line_row_projection.f =====
design/slrp_pkg.sv
design/slrp_in_stage.sv
design/slrp_row_core.sv
design/slrp_out_stage.sv
design/staff_line_row_projection.sv
verif/staff_line_row_projection_tb.sv
